@@ rtl/integer_to_radix_digits_core_assert.svh @@
// Assertion macros for the radix digit converter.
// Used by the checker module; no other dependencies.
`ifndef INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define I2RD_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define I2RD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/i2rd_pkg.sv @@
// Shared constants and register codes for the radix digit converter.
// No dependencies.
package i2rd_pkg;

    // Default sizes
    localparam int MAX_DIGITS_DEF = 32;
    localparam int VALUE_BITS_DEF = 31;

    // Field widths
    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Radix clamp limits
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd40;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_4 = 3'd5;

    // Alphabet word select codes (digit bits 5..3)
    localparam logic [2:0] WORD_0 = 3'd0;
    localparam logic [2:0] WORD_1 = 3'd1;
    localparam logic [2:0] WORD_2 = 3'd2;
    localparam logic [2:0] WORD_3 = 3'd3;
    localparam logic [2:0] WORD_4 = 3'd4;

    typedef logic [CHAR_W-1:0] t_char;

endpackage

@@ rtl/i2rd_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on i2rd_pkg for the divisor width.
module i2rd_div #(
    parameter int VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [VALUE_BITS-1:0]       i_dividend,
    input  logic [i2rd_pkg::RADIX_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [VALUE_BITS-1:0]       o_quot,
    output logic [i2rd_pkg::RADIX_W-1:0] o_rem
);
    import i2rd_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_acc;
    logic [RADIX_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_run;
    logic                  r_done;

    logic [RADIX_W:0]      w_shift;
    logic [RADIX_W:0]      w_diff;
    logic                  w_qbit;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_shift = {r_rem, r_acc[VALUE_BITS-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_qbit  = ~w_diff[RADIX_W];

    // Control: count down one step per quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(VALUE_BITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_acc <= {r_acc[VALUE_BITS-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[RADIX_W-1:0] : w_shift[RADIX_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc;
    assign o_rem  = r_rem;

endmodule

@@ rtl/integer_to_radix_digits_core.sv @@
// Top level of the radix digit converter: sequencer, digit buffer, alphabet.
// Depends on i2rd_pkg and i2rd_div.
//
// Usage: pulse start with i_magnitude while busy is low; the value is taken
// at that edge and busy rises. The block divides the value by the radix
// with a bit-serial divider, storing each remainder in a small digit
// buffer, until the quotient is zero. The digits are then played out
// most significant first, each beat a buffer read and then a character
// lookup, each beat shown for one cycle on o_digit_char with o_strobe
// high and o_is_last high on the final digit. At the default sizes the
// longest conversion is radix 2 with 31 digits.
// busy drops as the last beat is registered, so a new start may coincide
// with the last beat. The receiver cannot stall; beats are never held.
// Configuration: i_cfg_valid/o_cfg_ready write channel, always ready, with
// register index 0 the radix and 1..5 the alphabet words; write only while
// busy is low. Reset sets radix 10, clears the alphabet and the sequencer.
// Radix values below 2 act as 2 and above 40 act as 40.
module integer_to_radix_digits_core #(
    parameter int MAX_DIGITS = i2rd_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [VALUE_BITS-1:0]         i_magnitude,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [i2rd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [i2rd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                          o_strobe,
    output logic [i2rd_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                          o_is_last
);
    import i2rd_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int NW = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV_GO = 3'd1;
    localparam logic [2:0] S_DIV_WT = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    // Configuration registers
    logic [RADIX_W-1:0]   r_radix;
    logic [CFG_DAT_W-1:0] r_chars_0;
    logic [CFG_DAT_W-1:0] r_chars_1;
    logic [CFG_DAT_W-1:0] r_chars_2;
    logic [CFG_DAT_W-1:0] r_chars_3;
    logic [CFG_DAT_W-1:0] r_chars_4;

    // Sequencer and datapath
    logic [2:0]            r_state;
    logic [VALUE_BITS-1:0] r_val;
    logic [NW-1:0]         r_n;
    logic [AW-1:0]         r_rd_ptr;
    logic [RADIX_W-1:0]    r_rd_digit;
    logic                  r_strobe;
    t_char                 r_out_char;
    logic                  r_out_last;

    // Digit buffer
    logic [RADIX_W-1:0]    mem_digits [MAX_DIGITS];

    logic                  w_accept;
    logic [RADIX_W-1:0]    w_radix;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [VALUE_BITS-1:0] w_quot;
    logic [RADIX_W-1:0]    w_rem;
    logic                  w_room;
    logic [AW-1:0]         w_top_ptr;
    logic [CFG_DAT_W-1:0]  w_word;
    t_char                 w_char;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Clamp the radix to its legal range
    always_comb begin
        if (r_radix < RADIX_MIN) begin
            w_radix = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            w_radix = RADIX_MAX;
        end else begin
            w_radix = r_radix;
        end
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix   <= RADIX_RESET;
            r_chars_0 <= '0;
            r_chars_1 <= '0;
            r_chars_2 <= '0;
            r_chars_3 <= '0;
            r_chars_4 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RADIX:   r_radix   <= i_cfg_data[RADIX_W-1:0];
                REG_CHARS_0: r_chars_0 <= i_cfg_data;
                REG_CHARS_1: r_chars_1 <= i_cfg_data;
                REG_CHARS_2: r_chars_2 <= i_cfg_data;
                REG_CHARS_3: r_chars_3 <= i_cfg_data;
                REG_CHARS_4: r_chars_4 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared divider
    assign w_div_start = (r_state == S_DIV_GO);

    i2rd_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_val),
        .i_divisor  (w_radix),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Keep only the least significant MAX_DIGITS digits
    assign w_room    = (r_n != NW'(MAX_DIGITS));
    assign w_top_ptr = w_room ? r_n[AW-1:0] : AW'(r_n - 1'b1);

    // Store remainders, read the buffer one entry per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV_WT && w_div_done && w_room) begin
            mem_digits[r_n[AW-1:0]] <= w_rem;
        end
        r_rd_digit <= mem_digits[r_rd_ptr];
    end

    // Map a digit to its alphabet byte
    always_comb begin
        unique case (r_rd_digit[RADIX_W-1:3])
            WORD_0:  w_word = r_chars_0;
            WORD_1:  w_word = r_chars_1;
            WORD_2:  w_word = r_chars_2;
            WORD_3:  w_word = r_chars_3;
            WORD_4:  w_word = r_chars_4;
            default: w_word = '0;
        endcase
        w_char = w_word[{r_rd_digit[2:0], 3'b000} +: CHAR_W];
    end

    // Sequencer: divide until quotient is zero, then play digits out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_n      <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n     <= '0;
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WT;
                end
                S_DIV_WT: begin
                    if (w_div_done) begin
                        if (w_room) begin
                            r_n <= r_n + 1'b1;
                        end
                        if (w_quot == '0) begin
                            r_rd_ptr <= w_top_ptr;
                            r_state  <= S_RD;
                        end else begin
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_rd_ptr == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_rd_ptr <= r_rd_ptr - 1'b1;
                        r_state  <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Value register: load on accept, advance with each quotient
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val <= i_magnitude;
        end else if (r_state == S_DIV_WT && w_div_done) begin
            r_val <= w_quot;
        end
    end

    // Output beat registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_out_char <= w_char;
            r_out_last <= (r_rd_ptr == '0);
        end
    end

    assign o_strobe     = r_strobe;
    assign o_digit_char = r_out_char;
    assign o_is_last    = r_out_last;

endmodule

@@ rtl/i2rd_checker.sv @@
// Port-level checks for the radix digit converter, bound to the top level.
// Depends on integer_to_radix_digits_core_assert.svh.
`include "integer_to_radix_digits_core_assert.svh"

module i2rd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_is_last
);

    // An accepted start keeps the block busy for the next cycle
    `I2RD_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after start")

    // No beat leaves right after a value is taken
    `I2RD_ASSERT_NEXT(a_no_early_beat, i_clk, i_rst_n, start && !busy, !o_strobe, "beat right after start")

    // A digit that is not the last one means more work remains
    `I2RD_ASSERT_NEXT(a_more_digits, i_clk, i_rst_n, o_strobe && !o_is_last, busy, "idle with digits left")

    // Beats are never issued back to back
    `I2RD_ASSERT_NEXT(a_beat_spacing, i_clk, i_rst_n, o_strobe, !o_strobe, "back to back beats")

endmodule

bind integer_to_radix_digits_core i2rd_checker u_i2rd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_strobe  (o_strobe),
    .o_is_last (o_is_last)
);

@@ tb/sv/radix_digits_checker.sv @@
// Checker for the radix digit converter: watches the command, result and
// register channels, predicts each digit beat and compares. Depends on i2rd_pkg.
module radix_digits_checker #(
    parameter int VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = i2rd_pkg::MAX_DIGITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [VALUE_BITS-1:0]          i_magnitude,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [i2rd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [i2rd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_strobe,
    input  logic [i2rd_pkg::CHAR_W-1:0]    i_digit_char,
    input  logic                           i_is_last,
    output int                             o_fail_count,
    output int                             o_chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import i2rd_pkg::*;

    localparam int ALPHABET_WORDS = 5;
    localparam int ALPHABET_SIZE  = 40;

    typedef struct packed {
        t_char digit_char;
        logic  is_last;
    } t_digit_beat;

    // Local copy of the register file
    logic [RADIX_W-1:0]   radix_reg;
    logic [CFG_DAT_W-1:0] alphabet [ALPHABET_WORDS];

    t_digit_beat digit_q [$];
    t_digit_beat beat;
    int          fail_count;

    // Clamp the programmed radix into the supported range
    function automatic int unsigned base_in_use();
        if (radix_reg < RADIX_MIN) return RADIX_MIN;
        if (radix_reg > RADIX_MAX) return RADIX_MAX;
        return radix_reg;
    endfunction

    function automatic t_char char_for(int unsigned digit);
        logic [CFG_DAT_W-1:0] word;
        if (digit >= ALPHABET_SIZE) return '0;
        word = alphabet[digit / 8];
        return word[(digit % 8) * CHAR_W +: CHAR_W];
    endfunction

    // Divide repeatedly, then queue the characters most significant first
    function automatic void spell_digits(logic [VALUE_BITS-1:0] mag);
        int unsigned       digits [$];
        longint unsigned   rest;
        int unsigned       base;
        t_digit_beat       next_beat;
        base = base_in_use();
        rest = mag;
        do begin
            if (digits.size() < MAX_DIGITS) digits.push_back(32'(rest % base));
            rest = rest / base;
        end while (rest != 0);
        for (int k = digits.size() - 1; k >= 0; k--) begin
            next_beat.digit_char = char_for(digits[k]);
            next_beat.is_last    = (k == 0);
            digit_q.push_back(next_beat);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_reg = RADIX_RESET;
            foreach (alphabet[w]) alphabet[w] = '0;
            digit_q.delete();
            fail_count = 0;
        end else begin
            // Compare each digit beat with the oldest expectation
            if (i_strobe) begin
                if (digit_q.size() == 0) begin
                    $display("%0t: digit beat with none expected, char %02h last %0b",
                             $time, i_digit_char, i_is_last);
                    fail_count++;
                end else begin
                    beat = digit_q.pop_front();
                    if (i_digit_char !== beat.digit_char) begin
                        $display("%0t: digit_char mismatch, expected %02h, actual %02h",
                                 $time, beat.digit_char, i_digit_char);
                        fail_count++;
                    end
                    if (i_is_last !== beat.is_last) begin
                        $display("%0t: is_last mismatch, expected %0b, actual %0b",
                                 $time, beat.is_last, i_is_last);
                        fail_count++;
                    end
                end
            end

            // Predict on each accepted command
            if (i_start && !i_busy) spell_digits(i_magnitude);

            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RADIX:   radix_reg   = i_cfg_data[RADIX_W-1:0];
                    REG_CHARS_0: alphabet[0] = i_cfg_data;
                    REG_CHARS_1: alphabet[1] = i_cfg_data;
                    REG_CHARS_2: alphabet[2] = i_cfg_data;
                    REG_CHARS_3: alphabet[3] = i_cfg_data;
                    REG_CHARS_4: alphabet[4] = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_chars_pending <= digit_q.size();
        o_fail_count    <= fail_count;
    end

endmodule

@@ tb/sv/tb_integer_to_radix_digits_core.sv @@
// Testbench top for the radix digit converter: clock, reset, commands and
// register writes. Depends on i2rd_pkg, the converter RTL and radix_digits_checker.
module tb_integer_to_radix_digits_core;
    timeunit 1ns;
    timeprecision 1ps;
    import i2rd_pkg::*;

    localparam int                    VALUE_BITS   = VALUE_BITS_DEF;
    localparam longint                CYCLE_LIMIT  = 1_000_000;
    localparam int                    DRAIN_CYCLES = 64;
    localparam int                    RAND_PHASES  = 6;
    localparam int                    PHASE_ITEMS  = 15;
    localparam logic [VALUE_BITS-1:0] MAG_MAX      = '1;

    // Indexes outside the register file; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CHAR_REGS [5] =
        '{REG_CHARS_0, REG_CHARS_1, REG_CHARS_2, REG_CHARS_3, REG_CHARS_4};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [VALUE_BITS-1:0] i_magnitude = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_RADIX;
    logic [CFG_DAT_W-1:0]  i_cfg_data  = '0;
    logic                  o_strobe;
    logic [CHAR_W-1:0]     o_digit_char;
    logic                  o_is_last;

    int          fail_count;
    int          chars_pending;
    longint      cycle_count = 0;
    int unsigned cur_base    = 10;
    bit          steady      = 1'b0;

    integer_to_radix_digits_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_magnitude  (i_magnitude),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_is_last    (o_is_last)
    );

    radix_digits_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_magnitude     (i_magnitude),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_strobe        (o_strobe),
        .i_digit_char    (o_digit_char),
        .i_is_last       (o_is_last),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Issue one conversion command; returns at the falling edge after the command is taken
    task automatic put_magnitude(input logic [VALUE_BITS-1:0] mag);
        while (!steady && $urandom_range(99) < 37) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start       <= 1'b1;
        i_magnitude <= mag;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Write one register; valid is left high for a back-to-back beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        while (!steady && $urandom_range(99) < 37) begin
            i_cfg_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        if (idx == REG_RADIX) begin
            cur_base = (data[RADIX_W-1:0] < RADIX_MIN) ? RADIX_MIN :
                       (data[RADIX_W-1:0] > RADIX_MAX) ? RADIX_MAX : data[RADIX_W-1:0];
        end
    endtask

    // Drop start and wait until every expected digit has come out
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0 || busy);
        @(negedge i_clk);
    endtask

    // Reprogram once idle: radix, all or some alphabet words, sometimes a spare index
    task automatic program_base(input logic [RADIX_W-1:0] radix, input bit all_words);
        wait_drained();
        write_reg(REG_RADIX, {{(CFG_DAT_W-RADIX_W){1'b0}}, radix});
        foreach (CHAR_REGS[w]) begin
            if (all_words || $urandom_range(1)) write_reg(CHAR_REGS[w], {$urandom, $urandom});
        end
        if (!all_words && $urandom_range(3) == 0) begin
            write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [RADIX_W-1:0] pick_radix();
        case ($urandom_range(7))
            0:       return RADIX_W'($urandom_range(1));
            1:       return RADIX_W'($urandom_range(63, 41));
            default: return RADIX_W'($urandom_range(40, 2));
        endcase
    endfunction

    // Favor digit-count boundaries; otherwise random lengths and content
    function automatic logic [VALUE_BITS-1:0] pick_magnitude();
        longint unsigned       pow;
        int                    exp;
        logic [VALUE_BITS-1:0] raw;
        pow = 1;
        raw = VALUE_BITS'($urandom);
        case ($urandom_range(9))
            0: return '0;
            1: return MAG_MAX;
            2, 3: begin
                exp = $urandom_range(VALUE_BITS, 1);
                repeat (exp) if (pow * cur_base <= MAG_MAX) pow = pow * cur_base;
                return $urandom_range(1) ? VALUE_BITS'(pow) : VALUE_BITS'(pow - 1);
            end
            default: return raw >> $urandom_range(VALUE_BITS - 1);
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values: radix ten, blank alphabet
        put_magnitude('0);
        put_magnitude(VALUE_BITS'(12345));

        // Decimal with a full alphabet: digit-count edges and full range
        program_base(RADIX_W'(10), 1'b1);
        put_magnitude('0);
        put_magnitude(VALUE_BITS'(1));
        put_magnitude(VALUE_BITS'(9));
        put_magnitude(VALUE_BITS'(10));
        put_magnitude(VALUE_BITS'(99));
        put_magnitude(VALUE_BITS'(100));
        put_magnitude(MAG_MAX);
        put_magnitude(VALUE_BITS'(1) << (VALUE_BITS - 1));

        // Smallest radix: longest digit strings
        program_base(RADIX_MIN, 1'b0);
        put_magnitude(MAG_MAX);
        put_magnitude(VALUE_BITS'(1));
        put_magnitude(VALUE_BITS'(1) << (VALUE_BITS - 1));
        put_magnitude('0);

        // Largest radix: top of the alphabet
        program_base(RADIX_MAX, 1'b0);
        put_magnitude(VALUE_BITS'(39));
        put_magnitude(VALUE_BITS'(40));
        put_magnitude(VALUE_BITS'(1599));
        put_magnitude(VALUE_BITS'(1600));
        put_magnitude(MAG_MAX);

        // Out-of-range radix values clamp to the limits
        program_base(RADIX_W'(0), 1'b0);
        put_magnitude(VALUE_BITS'(5));
        program_base(RADIX_W'(1), 1'b0);
        put_magnitude(VALUE_BITS'(6));
        program_base(RADIX_W'(41), 1'b0);
        put_magnitude(MAG_MAX);
        program_base(RADIX_W'(63), 1'b0);
        put_magnitude(VALUE_BITS'(1600));
        program_base(RADIX_W'(16), 1'b0);
        put_magnitude(VALUE_BITS'(255));

        // Random phases; one runs without any idle cycles
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            steady = 1'b0;
            program_base(pick_radix(), 1'b0);
            steady = (phase == 2);
            repeat (PHASE_ITEMS) put_magnitude(pick_magnitude());
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/i2rd_pkg.sv
rtl/i2rd_div.sv
rtl/integer_to_radix_digits_core.sv
rtl/i2rd_checker.sv
tb/sv/radix_digits_checker.sv
tb/sv/tb_integer_to_radix_digits_core.sv
